### rtl/assoc_cache_oldest_evict_assert.svh
// Assertion macros used by the checker file of the cache block.
// Both macros sample on the rising edge of clk; the second ignores cycles in reset.
`ifndef ASSOC_CACHE_OLDEST_EVICT_ASSERT_SVH
`define ASSOC_CACHE_OLDEST_EVICT_ASSERT_SVH

`define ACOE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`define ACOE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### rtl/acoe_pkg.sv
package acoe_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int DATA_WIDTH_DEF = 64;

  localparam int CFG_W     = 5;
  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 64;
  localparam int SLOT_W    = 4;
  localparam int AGE_W     = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef struct packed {
    logic start;
    logic scan;
    logic fetch;
    logic write;
  } acoe_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } acoe_status_t;

endpackage

### rtl/acoe_if.sv
interface acoe_req_if;
  import acoe_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [KEY_W-1:0]     key;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, output mode, output key, output payload, input ready);
  modport sink (input valid, input mode, input key, input payload, output ready);
endinterface

interface acoe_rsp_if;
  import acoe_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 status;
  logic [SLOT_W-1:0]    slot;
  logic                 evicted;
  logic [KEY_W-1:0]     evicted_key;
  logic [PAYLOAD_W-1:0] evicted_payload;

  modport source (output valid, output status, output slot, output evicted,
                  output evicted_key, output evicted_payload, input ready);
  modport sink (input valid, input status, input slot, input evicted,
                input evicted_key, input evicted_payload, output ready);
endinterface

### rtl/assoc_cache_oldest_evict.sv
// Fully associative keyed cache with oldest-entry replacement. An insert beat
// fills the lowest free slot among the slots in use, or evicts the valid slot
// with the smallest age stamp (lowest index on ties) and returns its key and
// payload; an update beat rewrites the payload of the lowest matching valid slot
// or reports a miss. A request beat is accepted only while the controller is idle;
// the datapath then walks the key and age memory one slot per cycle through its
// single read port over the slots in use, fetches the chosen slot and, once the
// response register is free, writes it and loads the response register. A
// response beat waits in its own register, so a new request is taken while it is
// still held. All slots are invalid after reset and the slots-in-use register
// resets to sixteen.
module assoc_cache_oldest_evict #(
  parameter int ENTRIES    = acoe_pkg::ENTRIES_DEF,
  parameter int DATA_WIDTH = acoe_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [acoe_pkg::CFG_W-1:0] cfg_data,
  acoe_req_if.sink                   req,
  acoe_rsp_if.source                 rsp
);
  import acoe_pkg::*;

  acoe_cmd_t    cmd;
  acoe_status_t status;

  acoe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  acoe_datapath #(
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .in_mode             (req.mode),
    .in_key              (req.key),
    .in_payload          (req.payload),
    .out_valid           (rsp.valid),
    .out_ready           (rsp.ready),
    .out_status          (rsp.status),
    .out_slot            (rsp.slot),
    .out_evicted         (rsp.evicted),
    .out_evicted_key     (rsp.evicted_key),
    .out_evicted_payload (rsp.evicted_payload)
  );

endmodule

### rtl/acoe_ctrl.sv
module acoe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  acoe_pkg::acoe_status_t status,
  output acoe_pkg::acoe_cmd_t    cmd
);
  import acoe_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FETCH,
    WRITE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = SCAN;
        end
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = FETCH;
        end
      end
      FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = WRITE;
      end
      WRITE: begin
        if (status.out_free) begin
          cmd.write  = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/acoe_datapath.sv
module acoe_datapath #(
  parameter int ENTRIES    = acoe_pkg::ENTRIES_DEF,
  parameter int DATA_WIDTH = acoe_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  acoe_pkg::acoe_cmd_t            cmd,
  output acoe_pkg::acoe_status_t         status,
  input  logic                           cfg_we,
  input  logic [acoe_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_mode,
  input  logic [acoe_pkg::KEY_W-1:0]     in_key,
  input  logic [acoe_pkg::PAYLOAD_W-1:0] in_payload,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_status,
  output logic [acoe_pkg::SLOT_W-1:0]    out_slot,
  output logic                           out_evicted,
  output logic [acoe_pkg::KEY_W-1:0]     out_evicted_key,
  output logic [acoe_pkg::PAYLOAD_W-1:0] out_evicted_payload
);
  import acoe_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [CFG_W-1:0]      cfg;
  logic [CW-1:0]         n_used;

  logic                  mode_r;
  logic [KEY_W-1:0]      key_r;
  logic [DATA_WIDTH-1:0] pay_r;

  logic [CW-1:0]         idx;
  logic [AW-1:0]         pj;
  logic                  pv;
  logic                  found;
  logic [AW-1:0]         target;
  logic [AW-1:0]         victim;
  logic [AGE_W-1:0]      best_age;
  logic [AGE_W-1:0]      age_counter;
  logic [ENTRIES-1:0]    valid_bits;

  logic [KEY_W-1:0]      keys_mem [ENTRIES];
  logic [DATA_WIDTH-1:0] pays_mem [ENTRIES];
  logic [AGE_W-1:0]      ages_mem [ENTRIES];

  logic [KEY_W-1:0]      rd_key;
  logic [DATA_WIDTH-1:0] rd_pay;
  logic [AGE_W-1:0]      rd_age;

  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_slot;
  logic                  idx_live;
  logic                  slot_valid;
  logic                  hit;
  logic                  evict;

  always_comb begin
    int n_int;
    n_int = int'(cfg);
    if (n_int == 0) begin
      n_int = 1;
    end
    if (n_int > ENTRIES) begin
      n_int = ENTRIES;
    end
    n_used = CW'(n_int);
  end

  assign idx_live   = idx < n_used;
  assign wr_slot    = found ? target : victim;
  assign slot_valid = valid_bits[pj];
  assign hit        = (mode_r == MODE_INSERT) || found;
  assign evict      = (mode_r == MODE_INSERT) && !found;

  always_comb begin
    if (cmd.fetch) begin
      rd_addr = wr_slot;
    end else if (idx_live) begin
      rd_addr = idx[AW-1:0];
    end else begin
      rd_addr = target;
    end
  end

  assign status.scan_done = cmd.scan && pv && (CW'(pj) == n_used - CW'(1));
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      cfg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= keys_mem[rd_addr];
    rd_pay <= pays_mem[rd_addr];
    rd_age <= ages_mem[rd_addr];
    if (cmd.write && hit) begin
      pays_mem[target] <= pay_r;
      ages_mem[target] <= age_counter;
      if (mode_r == MODE_INSERT) begin
        keys_mem[target] <= key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      pay_r  <= in_payload[DATA_WIDTH-1:0];
      idx    <= '0;
      found  <= 1'b0;
    end
    if (cmd.scan) begin
      pj <= idx[AW-1:0];
      if (idx_live) begin
        idx <= idx + CW'(1);
      end
      if (pv && !found) begin
        if (mode_r == MODE_INSERT) begin
          if (!slot_valid) begin
            found  <= 1'b1;
            target <= pj;
          end
          if ((pj == '0) || (rd_age < best_age)) begin
            best_age <= rd_age;
            victim   <= pj;
          end
        end else if (slot_valid && (rd_key == key_r)) begin
          found  <= 1'b1;
          target <= pj;
        end
      end
    end
    if (cmd.fetch) begin
      target <= wr_slot;
    end
    if (cmd.write) begin
      out_status          <= hit ? STATUS_DONE : STATUS_MISS;
      out_slot            <= hit ? SLOT_W'(target) : '0;
      out_evicted         <= evict;
      out_evicted_key     <= evict ? rd_key : '0;
      out_evicted_payload <= evict ? PAYLOAD_W'(rd_pay) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv          <= 1'b0;
      age_counter <= '0;
      valid_bits  <= '0;
      out_valid   <= 1'b0;
    end else begin
      pv <= cmd.scan && idx_live;
      if (cmd.write) begin
        out_valid <= 1'b1;
        if (hit) begin
          age_counter        <= age_counter + AGE_W'(1);
          valid_bits[target] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/acoe_checker.sv
`include "assoc_cache_oldest_evict_assert.svh"

module acoe_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic                           rsp_status,
  input logic [acoe_pkg::SLOT_W-1:0]    rsp_slot,
  input logic                           rsp_evicted,
  input logic [acoe_pkg::KEY_W-1:0]     rsp_evicted_key,
  input logic [acoe_pkg::PAYLOAD_W-1:0] rsp_evicted_payload
);
  import acoe_pkg::*;

  `ACOE_ASSERT(a_reset_clears_rsp, rst |=> !rsp_valid, "response valid after reset")
  `ACOE_ASSERT_RST(a_rsp_held, rsp_valid && !rsp_ready |=> rsp_valid, "stalled response dropped")
  `ACOE_ASSERT_RST(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "request taken while busy")
  `ACOE_ASSERT_RST(a_miss_clean, rsp_valid && (rsp_status == STATUS_MISS) |-> (rsp_slot == '0) && !rsp_evicted && (rsp_evicted_key == '0) && (rsp_evicted_payload == '0), "miss response carries data")
  `ACOE_ASSERT_RST(a_no_evict_clean, rsp_valid && !rsp_evicted |-> (rsp_evicted_key == '0) && (rsp_evicted_payload == '0), "eviction data without eviction")

endmodule

bind assoc_cache_oldest_evict acoe_checker u_acoe_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_status          (rsp.status),
  .rsp_slot            (rsp.slot),
  .rsp_evicted         (rsp.evicted),
  .rsp_evicted_key     (rsp.evicted_key),
  .rsp_evicted_payload (rsp.evicted_payload)
);

### tb/acoe_access_checker.sv
module acoe_access_checker
  import acoe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  acoe_req_if              req,
  acoe_rsp_if              rsp,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 status;
    logic [SLOT_W-1:0]    slot;
    logic                 evicted;
    logic [KEY_W-1:0]     evicted_key;
    logic [PAYLOAD_W-1:0] evicted_payload;
  } access_result_t;

  access_result_t       awaited_results[$];
  logic                 slot_valid[ENTRIES_DEF];
  logic [KEY_W-1:0]     slot_key[ENTRIES_DEF];
  logic [PAYLOAD_W-1:0] slot_data[ENTRIES_DEF];
  logic [AGE_W-1:0]     slot_age[ENTRIES_DEF];
  logic [AGE_W-1:0]     age_now;
  logic [CFG_W-1:0]     slots_cfg;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Applies one request beat to the shadow table and returns the response it should produce.
  function automatic access_result_t apply_access(input logic mode, input logic [KEY_W-1:0] key,
                                                  input logic [PAYLOAD_W-1:0] data);
    access_result_t r;
    int n;
    int target;
    bit hit;
    r = '0;
    target = 0;
    hit = 0;
    n = (slots_cfg == 0) ? 1 : ((slots_cfg > ENTRIES_DEF) ? ENTRIES_DEF : int'(slots_cfg));
    if (mode == MODE_INSERT) begin
      for (int i = 0; i < n; i++) begin
        if (!hit && !slot_valid[i]) begin
          target = i;
          hit = 1;
        end
      end
      if (!hit) begin
        for (int i = 1; i < n; i++) begin
          if (slot_age[i] < slot_age[target]) target = i;
        end
        r.evicted = 1'b1;
        r.evicted_key = slot_key[target];
        r.evicted_payload = slot_data[target];
      end
      slot_valid[target] = 1'b1;
      slot_key[target] = key;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!hit && slot_valid[i] && slot_key[i] == key) begin
          target = i;
          hit = 1;
        end
      end
      if (!hit) begin
        r.status = STATUS_MISS;
        return r;
      end
    end
    slot_data[target] = data;
    slot_age[target] = age_now;
    age_now = age_now + 1'b1;
    r.status = STATUS_DONE;
    r.slot = SLOT_W'(target);
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES_DEF; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i] = '0;
        slot_data[i] = '0;
        slot_age[i] = '0;
      end
      age_now = '0;
      slots_cfg = CFG_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_we) slots_cfg = cfg_data;
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $error("response beat with no request outstanding");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", 64'(want.status), 64'(rsp.status));
          compare_field("slot", 64'(want.slot), 64'(rsp.slot));
          compare_field("evicted", 64'(want.evicted), 64'(rsp.evicted));
          compare_field("evicted_key", 64'(want.evicted_key), 64'(rsp.evicted_key));
          compare_field("evicted_payload", want.evicted_payload, rsp.evicted_payload);
        end
      end
      if (req.valid && req.ready) begin
        awaited_results.push_back(apply_access(req.mode, req.key, req.payload));
      end
    end
    pending = awaited_results.size();
  end

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import acoe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  int               fail_count;
  int               pending;
  int               cycle_count = 0;
  bit               src_idle_on = 1'b1;
  bit               sink_idle_on = 1'b1;

  acoe_req_if req_ch ();
  acoe_rsp_if rsp_ch ();

  always #5 clk = ~clk;

  assoc_cache_oldest_evict dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  acoe_access_checker access_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL assoc_cache_oldest_evict");
      $finish;
    end
  end

  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = sink_idle_on ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_beat(input logic mode, input logic [KEY_W-1:0] key,
                           input logic [PAYLOAD_W-1:0] data);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= mode;
    req_ch.key <= key;
    req_ch.payload <= data;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_slots(input logic [CFG_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    logic [KEY_W-1:0] key_pool[8];
    logic [KEY_W-1:0] key;
    logic [PAYLOAD_W-1:0] data;
    int pick;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom;
    for (int i = 0; i < count; i++) begin
      key = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(0, 7)];
      pick = $urandom_range(0, 9);
      if (pick == 0) data = '0;
      else if (pick == 1) data = '1;
      else data = {$urandom, $urandom};
      send_beat($urandom_range(0, 1) ? MODE_UPDATE : MODE_INSERT, key, data);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_slots[10];
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_INSERT;
    req_ch.key = '0;
    req_ch.payload = '0;
    phase_slots = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd17, 5'd2, 5'd16, 5'd5};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(MODE_UPDATE, 32'h0, 64'h1);
    send_beat(MODE_INSERT, 32'h0, 64'h0);
    send_beat(MODE_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(MODE_UPDATE, 32'hFFFF_FFFF, 64'h0);
    send_beat(MODE_UPDATE, 32'h1234_5678, 64'hDEAD_BEEF_0000_0001);
    send_beat(MODE_INSERT, 32'h0, 64'h5555_5555_5555_5555);
    send_beat(MODE_UPDATE, 32'h0, 64'hAAAA_AAAA_AAAA_AAAA);
    set_slots(5'd2);
    send_beat(MODE_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0001);
    send_beat(MODE_INSERT, 32'h0000_0001, 64'h0123_4567_89AB_CDEF);
    send_beat(MODE_UPDATE, 32'h0000_0001, 64'hFEDC_BA98_7654_3210);
    send_beat(MODE_INSERT, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    set_slots(5'd0);
    send_beat(MODE_INSERT, 32'hA5A5_A5A5, 64'h1);
    send_beat(MODE_INSERT, 32'h5A5A_5A5A, 64'h2);
    send_beat(MODE_UPDATE, 32'hFFFF_FFFF, 64'h3);
    set_slots(5'd31);
    send_beat(MODE_INSERT, 32'hCAFE_0000, 64'h4);
    send_beat(MODE_UPDATE, 32'hCAFE_0000, 64'h5);

    for (int p = 0; p < 10; p++) begin
      set_slots(phase_slots[p]);
      src_idle_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      sink_idle_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      run_random(120);
    end

    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS assoc_cache_oldest_evict");
    end else begin
      $display("FAIL assoc_cache_oldest_evict");
    end
    $finish;
  end

endmodule
